// ----- hw/rtl/pidc_pkg.sv -----
// pidc_pkg: shared types and constants of the pid controller step unit
// depends on nothing
`timescale 1ns / 1ps
package pidc_pkg;

	localparam int unsigned NumRegs  = 8;
	localparam int unsigned AddrW    = 5;

	typedef enum logic [2:0] {
		REG_PROP  = 3'd0,
		REG_INTEG = 3'd1,
		REG_DERIV = 3'd2,
		REG_TSTEP = 3'd3,
		REG_LOW   = 3'd4,
		REG_HIGH  = 3'd5,
		REG_RATE  = 3'd6,
		REG_ASYM  = 3'd7
	} reg_idx_t;

	// datapath operations; each controller state issues one of them
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ERR,
		OP_ERR_SCALE,
		OP_KP,
		OP_KI1,
		OP_KI2,
		OP_SUM,
		OP_DIFF,
		OP_DQ,
		OP_KD,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ERR,
		ST_ERR_SCALE,
		ST_ERR_WAIT,
		ST_KP,
		ST_KP_WAIT,
		ST_KI1,
		ST_KI1_WAIT,
		ST_KI2,
		ST_KI2_WAIT,
		ST_SUM,
		ST_DIFF,
		ST_DQ,
		ST_DQ_WAIT,
		ST_KD,
		ST_KD_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic start_unit;
	} cmd_t;

	typedef struct packed {
		logic unit_done;
	} stat_t;

endpackage

// ----- hw/rtl/pidc_datapath.sv -----
// pidc_datapath: registers, shared multiply and iterative divide unit, and clamp logic
// depends on pidc_pkg
`timescale 1ns / 1ps
module pidc_datapath #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pidc_pkg::cmd_t       cmd,
	output pidc_pkg::stat_t      stat,
	input  logic signed [31:0]   feedback,
	input  logic signed [31:0]   target,
	input  logic signed [31:0]   prop_gain,
	input  logic signed [31:0]   integ_gain,
	input  logic signed [31:0]   deriv_gain,
	input  logic        [30:0]   time_step,
	input  logic signed [31:0]   out_low_limit,
	input  logic signed [31:0]   out_high_limit,
	input  logic        [30:0]   integ_rate_limit,
	input  logic        [30:0]   asym_gain,
	output logic signed [31:0]   drive,
	output logic                 held
);
	import pidc_pkg::*;

	localparam int unsigned SatW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
	localparam logic signed [63:0] SatMax = (64'sd1 <<< (SatW - 1)) - 64'sd1;
	localparam logic signed [63:0] SatMin = -SatMax - 64'sd1;
	// quotient magnitude: 32 + FRAC_BITS bits, one bit a cycle
	localparam int unsigned QW   = 32 + FRAC_BITS;
	localparam int unsigned CntW = $clog2(QW + 1);

	logic signed [31:0] fb_q, tg_q, err_q, kp_q, ki_q, sum_q, integ_q, prev_q, diff_q, dq_q;
	logic signed [31:0] drv_q;
	logic               held_q, held_out_q;

	// shared unit
	logic               unit_div_q, busy_q, done_q, neg_q;
	logic signed [31:0] ma_q, mb_q;
	logic        [63:0] prod_s1;
	logic               mul_pend_q;
	logic        [QW-1:0] quo_q, dvd_q;
	logic        [31:0] den_q;
	logic        [32:0] rem_q;
	logic [CntW-1:0]    cnt_q;
	logic signed [31:0] res_q;

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		logic signed [63:0] r;
		begin
			r = v;
			if (v > SatMax) r = SatMax;
			else if (v < SatMin) r = SatMin;
			sat64 = r[31:0];
		end
	endfunction

	// operand selection for the shared unit
	logic               sel_div;
	logic signed [31:0] sel_a, sel_b;
	always_comb begin
		sel_div = 1'b0;
		sel_a   = '0;
		sel_b   = '0;
		unique case (cmd.op)
			OP_ERR_SCALE: begin
				sel_div = (err_q > 0);
				sel_a   = err_q;
				sel_b   = {1'b0, asym_gain};
			end
			OP_KP: begin
				sel_a = prop_gain;
				sel_b = err_q;
			end
			OP_KI1: begin
				sel_a = integ_gain;
				sel_b = integ_q;
			end
			OP_KI2: begin
				sel_a = ki_q;
				sel_b = {1'b0, time_step};
			end
			OP_DQ: begin
				sel_div = 1'b1;
				sel_a   = diff_q;
				sel_b   = {1'b0, time_step};
			end
			OP_KD: begin
				sel_a = dq_q;
				sel_b = deriv_gain;
			end
			default: ;
		endcase
	end

	logic signed [63:0] prod_sh;
	logic [32:0] rem_try;
	logic [QW:0] mag_full;
	always_comb begin
		prod_sh = $signed(prod_s1) >>> FRAC_BITS;
		rem_try = {rem_q[31:0], dvd_q[QW-1]} - {1'b0, den_q};
		mag_full = {1'b0, quo_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			mul_pend_q <= 1'b0;
			unit_div_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start_unit) begin
				unit_div_q <= sel_div;
				if (sel_div && sel_b == 0) begin
					res_q  <= (sel_a > 0) ? SatMax[31:0] : ((sel_a < 0) ? SatMin[31:0] : 32'sd0);
					done_q <= 1'b1;
				end else if (sel_div) begin
					busy_q <= 1'b1;
					neg_q  <= sel_a[31];
					dvd_q  <= {(sel_a[31] ? 32'(-sel_a) : 32'(sel_a)), {FRAC_BITS{1'b0}}};
					den_q  <= sel_b;
					rem_q  <= '0;
					quo_q  <= '0;
					cnt_q  <= CntW'(QW);
				end else begin
					ma_q       <= sel_a;
					mb_q       <= sel_b;
					mul_pend_q <= 1'b1;
					busy_q     <= 1'b1;
				end
			end else if (busy_q && !unit_div_q) begin
				// multiply: product register then shift and saturate
				if (mul_pend_q) begin
					prod_s1    <= 64'(ma_q * mb_q);
					mul_pend_q <= 1'b0;
				end else begin
					res_q  <= sat64(prod_sh);
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				// restoring division, one quotient bit a cycle
				if (cnt_q != 0) begin
					dvd_q <= {dvd_q[QW-2:0], 1'b0};
					if (!rem_try[32]) begin
						rem_q <= rem_try;
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[31:0], dvd_q[QW-1]};
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
				end else begin
					res_q  <= sat64(neg_q ? -$signed(64'(mag_full)) : $signed(64'(mag_full)));
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.unit_done = done_q;

	logic signed [31:0] ichg;
	logic signed [31:0] rate_s;
	always_comb begin
		rate_s = {1'b0, integ_rate_limit};
		ichg   = err_q;
		if (err_q > rate_s) ichg = rate_s;
		else if (err_q < -rate_s) ichg = -rate_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_q     <= '0;
			held_q     <= 1'b0;
			held_out_q <= 1'b0;
			drv_q      <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					fb_q <= feedback;
					tg_q <= target;
				end
				OP_ERR: err_q <= sat64(64'(tg_q) - 64'(fb_q));
				OP_ERR_SCALE: if (done_q) err_q <= res_q;
				OP_KP:  if (done_q) kp_q <= res_q;
				OP_KI1: if (done_q) ki_q <= res_q;
				OP_KI2: if (done_q) ki_q <= res_q;
				OP_SUM: begin
					// sum of p and i; clamp and conditional integration
					if (sat64(64'(kp_q) + 64'(ki_q)) > out_high_limit) begin
						sum_q  <= out_high_limit;
						held_q <= 1'b1;
					end else if (sat64(64'(kp_q) + 64'(ki_q)) <= out_low_limit) begin
						sum_q  <= out_low_limit;
						held_q <= 1'b1;
					end else begin
						sum_q   <= sat64(64'(kp_q) + 64'(ki_q));
						held_q  <= 1'b0;
						integ_q <= sat64(64'(integ_q) + 64'(ichg));
					end
				end
				OP_DIFF: diff_q <= sat64(64'(fb_q) - 64'(prev_q));
				OP_DQ:  if (done_q) dq_q <= res_q;
				OP_KD:  if (done_q) dq_q <= res_q;
				OP_OUT: begin
					drv_q      <= sat64(64'(sum_q) + 64'(dq_q));
					held_out_q <= held_q;
					prev_q     <= fb_q;
				end
				default: ;
			endcase
		end
	end

	assign drive = drv_q;
	assign held  = held_out_q;

endmodule

// ----- hw/rtl/pidc_ctrl.sv -----
// pidc_ctrl: sequencer for one controller step
// depends on pidc_pkg
`timescale 1ns / 1ps
module pidc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            out_busy,
	output logic            in_ready,
	output logic            out_load,
	output pidc_pkg::cmd_t  cmd,
	input  pidc_pkg::stat_t stat
);
	import pidc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d        = state_q;
		cmd.op         = OP_NONE;
		cmd.start_unit = 1'b0;
		in_ready       = 1'b0;
		out_load       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.op   = OP_LOAD;
				if (in_fire) state_d = ST_ERR;
			end
			ST_ERR: begin
				cmd.op  = OP_ERR;
				state_d = ST_ERR_SCALE;
			end
			ST_ERR_SCALE: begin
				cmd.op = OP_ERR_SCALE; cmd.start_unit = 1'b1; state_d = ST_ERR_WAIT;
			end
			ST_ERR_WAIT: begin
				cmd.op = OP_ERR_SCALE; if (stat.unit_done) state_d = ST_KP;
			end
			ST_KP: begin
				cmd.op = OP_KP; cmd.start_unit = 1'b1; state_d = ST_KP_WAIT;
			end
			ST_KP_WAIT: begin
				cmd.op = OP_KP; if (stat.unit_done) state_d = ST_KI1;
			end
			ST_KI1: begin
				cmd.op = OP_KI1; cmd.start_unit = 1'b1; state_d = ST_KI1_WAIT;
			end
			ST_KI1_WAIT: begin
				cmd.op = OP_KI1; if (stat.unit_done) state_d = ST_KI2;
			end
			ST_KI2: begin
				cmd.op = OP_KI2; cmd.start_unit = 1'b1; state_d = ST_KI2_WAIT;
			end
			ST_KI2_WAIT: begin
				cmd.op = OP_KI2; if (stat.unit_done) state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.op = OP_SUM; state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.op = OP_DIFF; state_d = ST_DQ;
			end
			ST_DQ: begin
				cmd.op = OP_DQ; cmd.start_unit = 1'b1; state_d = ST_DQ_WAIT;
			end
			ST_DQ_WAIT: begin
				cmd.op = OP_DQ; if (stat.unit_done) state_d = ST_KD;
			end
			ST_KD: begin
				cmd.op = OP_KD; cmd.start_unit = 1'b1; state_d = ST_KD_WAIT;
			end
			ST_KD_WAIT: begin
				cmd.op = OP_KD; if (stat.unit_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the result register is free
				if (!out_busy) begin
					cmd.op   = OP_OUT;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/pid_controller_step_unit.sv -----
// pid_controller_step_unit: top level, apb register file, stream ports, controller and datapath
// depends on pidc_pkg, pidc_ctrl, pidc_datapath
// a step divides twice when the error is positive (error scale and derivative), once otherwise
// one step at a time, paced by the shared bit-serial divider; a new word enters only in idle
// the result register lets the next word enter while a result waits
// arst_n clears state, integrator and previous feedback; gains reset to 0, step and asym to 1.0
`timescale 1ns / 1ps
module pid_controller_step_unit #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [pidc_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // feedback[31:0], target[63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // drive[31:0]
	output logic        m_tuser    // held
);
	import pidc_pkg::*;

	logic signed [31:0] prop_q, integ_q, deriv_q, low_q, high_q;
	logic        [30:0] tstep_q, rate_q, asym_q;
	logic        [2:0]  idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= '0;
			integ_q <= '0;
			deriv_q <= '0;
			tstep_q <= 31'd65536;
			low_q   <= '0;
			high_q  <= '0;
			rate_q  <= '0;
			asym_q  <= 31'd65536;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			unique case (reg_idx_t'(idx))
				REG_PROP:  prop_q  <= pwdata;
				REG_INTEG: integ_q <= pwdata;
				REG_DERIV: deriv_q <= pwdata;
				REG_TSTEP: tstep_q <= pwdata[30:0];
				REG_LOW:   low_q   <= pwdata;
				REG_HIGH:  high_q  <= pwdata;
				REG_RATE:  rate_q  <= pwdata[30:0];
				REG_ASYM:  asym_q  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(idx))
			REG_PROP:  prdata = prop_q;
			REG_INTEG: prdata = integ_q;
			REG_DERIV: prdata = deriv_q;
			REG_TSTEP: prdata = {1'b0, tstep_q};
			REG_LOW:   prdata = low_q;
			REG_HIGH:  prdata = high_q;
			REG_RATE:  prdata = {1'b0, rate_q};
			REG_ASYM:  prdata = {1'b0, asym_q};
			default:   prdata = '0;
		endcase
	end

	cmd_t  cmd;
	stat_t stat;
	logic  out_load;
	logic  valid_q;
	logic signed [31:0] drv;
	logic  hld;

	pidc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (s_tvalid && s_tready),
		.out_busy (valid_q && !m_tready),
		.in_ready (s_tready),
		.out_load (out_load),
		.cmd      (cmd),
		.stat     (stat)
	);

	pidc_datapath #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.feedback         (s_tdata[31:0]),
		.target           (s_tdata[63:32]),
		.prop_gain        (prop_q),
		.integ_gain       (integ_q),
		.deriv_gain       (deriv_q),
		.time_step        (tstep_q),
		.out_low_limit    (low_q),
		.out_high_limit   (high_q),
		.integ_rate_limit (rate_q),
		.asym_gain        (asym_q),
		.drive            (drv),
		.held             (hld)
	);

	// result word valid flag; data sits in the datapath output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (out_load) valid_q <= 1'b1;
		else if (m_tready) valid_q <= 1'b0;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = drv;
	assign m_tuser  = hld;

endmodule
